// File: design/ahf_pkg.sv
// ahf_pkg: shared types and constants for the anchored headword filter.
// No dependencies; used by ahf_cell and anchored_headword_filter.
`timescale 1ns / 1ps

package ahf_pkg;

  localparam int unsigned PAT_BYTES = 32;   // pattern bytes held in config
  localparam int unsigned PB_W      = 5;    // index width into pattern bytes
  localparam int unsigned IDX_W     = 7;    // pattern position width (values up to 127)
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] NEWLINE = 8'd10;
  localparam logic [7:0] SPACE   = 8'd32;
  localparam logic [7:0] TAB     = 8'd9;
  localparam logic [7:0] CR      = 8'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_S = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_E = 3'd6;

  typedef logic [PAT_BYTES-1:0][7:0] pat_arr_t;

endpackage

// File: design/ahf_cell.sv
// ahf_cell: one window cell; holds one recent text byte, passes it to the
// next cell on every shift and compares its next value to its pattern byte.
// Depends on ahf_pkg.
`timescale 1ns / 1ps

module ahf_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [7:0]                   byte_i,
  input  ahf_pkg::pat_arr_t            pattern_i,
  input  logic [ahf_pkg::IDX_W-1:0]    pat_len_i,
  output logic [7:0]                   byte_o,
  output logic                         eq_o
);

  logic [7:0]                byte_q;
  logic [7:0]                byte_d;
  logic [ahf_pkg::IDX_W-1:0] pos;
  logic [ahf_pkg::IDX_W-1:0] pidx;
  logic                      in_use;
  logic [7:0]                pbyte;

  assign pos    = ahf_pkg::IDX_W'(POS);
  assign byte_d = shift_i ? byte_i : byte_q;
  assign in_use = pos < pat_len_i;
  // cell POS holds the byte POS places back, so it meets pattern byte n-1-POS
  assign pidx   = pat_len_i - pos - ahf_pkg::IDX_W'(1);

  always_comb begin
    if (pidx < ahf_pkg::IDX_W'(ahf_pkg::PAT_BYTES)) begin
      pbyte = pattern_i[pidx[ahf_pkg::PB_W-1:0]];
    end else begin
      pbyte = 8'd0;
    end
  end

  assign eq_o = !in_use || (byte_d == pbyte);

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// File: design/anchored_headword_filter.sv
// Anchored headword filter: one text byte per cycle unless a pending result stalls the input, one decision per line.
// Throughput: one byte transaction every cycle while no result waits untaken; the byte window compare runs
// in the same cycle across a chain of PATTERN_MAX cells.
// The line decision is registered in the cycle after the transaction
// that ends the line, and is held until taken.
// Reset (rst_ni low, asynchronous) clears line state, counter and config.
`timescale 1ns / 1ps

module anchored_headword_filter #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LINE_LIMIT  = 1023
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ahf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ahf_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            text_valid_i,
  output logic                            text_ready_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            text_done_i,
  output logic                            result_valid_o,
  input  logic                            result_ready_i,
  output logic                            line_shown_o,
  output logic                            numbered_headword_o,
  output logic [ahf_pkg::CNT_W-1:0]       entry_number_o,
  output logic                            last_line_o,
  output logic                            none_found_o
);

  localparam int unsigned LW = $clog2(LINE_LIMIT + 1);
  localparam int unsigned IW = ahf_pkg::IDX_W;
  localparam int unsigned CW = ahf_pkg::CNT_W;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == ahf_pkg::SPACE) || (b >= ahf_pkg::TAB && b <= ahf_pkg::CR);
  endfunction

  // configuration
  ahf_pkg::pat_arr_t pattern_q;
  logic [5:0]        plen_q;
  logic              anchor_s_q;
  logic              anchor_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      plen_q     <= 6'd1;
      anchor_s_q <= 1'b0;
      anchor_e_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        ahf_pkg::CFG_PAT0, ahf_pkg::CFG_PAT1,
        ahf_pkg::CFG_PAT2, ahf_pkg::CFG_PAT3: begin
          for (int i = 0; i < 8; i++) begin
            pattern_q[{cfg_index_i[1:0], 3'(i)}] <= cfg_data_i[8*i +: 8];
          end
        end
        ahf_pkg::CFG_PLEN:     plen_q     <= cfg_data_i[5:0];
        ahf_pkg::CFG_ANCHOR_S: anchor_s_q <= cfg_data_i[0];
        ahf_pkg::CFG_ANCHOR_E: anchor_e_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // effective pattern length, clipped to the window depth
  logic [IW-1:0] plen_ext;
  logic [IW-1:0] n_len;
  assign plen_ext = IW'(plen_q);
  assign n_len    = (plen_ext > IW'(PATTERN_MAX)) ? IW'(PATTERN_MAX) : plen_ext;

  // handshake
  logic in_fire;
  logic is_nl;
  logic byte_step;
  logic line_end;
  logic result_valid_q;

  assign text_ready_o = !result_valid_q || result_ready_i;
  assign in_fire      = text_valid_i && text_ready_o;
  assign is_nl        = text_byte_i == ahf_pkg::NEWLINE;
  assign byte_step    = in_fire && !is_nl;
  assign line_end     = in_fire && (is_nl || text_done_i);

  // window cell chain
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0]      eq;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] feed;
    if (k == 0) begin : g_head
      assign feed = text_byte_i;
    end else begin : g_body
      assign feed = win[k-1];
    end
    ahf_cell #(
      .POS (k)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (byte_step),
      .byte_i    (feed),
      .pattern_i (pattern_q),
      .pat_len_i (n_len),
      .byte_o    (win[k]),
      .eq_o      (eq[k])
    );
  end

  // line state
  logic [LW-1:0] len_q, len_nx;
  logic          head_q, head_nx;
  logic          seen_any_q, seen_start_q;
  logic          sel_q;
  logic [CW-1:0] cnt_q;

  logic          ends, len_is_n, n_zero;
  logic          sa, ss, hit;
  logic          sel_new;
  logic [CW-1:0] cnt_new;

  always_comb begin
    if (byte_step && len_q != LW'(LINE_LIMIT)) begin
      len_nx = len_q + LW'(1);
    end else begin
      len_nx = len_q;
    end
  end

  assign head_nx  = (len_q == '0) ? !is_space(text_byte_i) : head_q;
  assign ends     = (&eq) && (len_nx >= LW'(n_len));
  assign len_is_n = len_nx == LW'(n_len);
  assign n_zero   = n_len == '0;
  assign sa       = seen_any_q || (byte_step && ends) || n_zero;
  assign ss       = seen_start_q || (byte_step && ends && len_is_n) || n_zero;

  always_comb begin
    case ({anchor_s_q, anchor_e_q})
      2'b11:   hit = ends && len_is_n;
      2'b10:   hit = ss;
      2'b01:   hit = ends;
      default: hit = sa;
    endcase
  end

  assign sel_new = head_nx ? hit : sel_q;
  assign cnt_new = (head_nx && hit && cnt_q != '1) ? cnt_q + CW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      head_q       <= 1'b0;
      seen_any_q   <= 1'b0;
      seen_start_q <= 1'b0;
      sel_q        <= 1'b0;
      cnt_q        <= '0;
    end else if (in_fire) begin
      if (line_end) begin
        len_q        <= '0;
        head_q       <= 1'b0;
        seen_any_q   <= 1'b0;
        seen_start_q <= 1'b0;
        // final byte returns the entry state to its start
        sel_q        <= text_done_i ? 1'b0 : sel_new;
        cnt_q        <= text_done_i ? '0 : cnt_new;
      end else begin
        len_q        <= len_nx;
        head_q       <= head_nx;
        seen_any_q   <= seen_any_q || ends;
        seen_start_q <= seen_start_q || (ends && len_is_n);
      end
    end
  end

  // result register
  logic          shown_q, numbered_q, last_q, none_q;
  logic [CW-1:0] number_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (line_end) begin
      result_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_end) begin
      shown_q    <= sel_new;
      numbered_q <= head_nx && hit;
      number_q   <= cnt_new;
      last_q     <= text_done_i;
      none_q     <= text_done_i && (cnt_new == '0);
    end
  end

  assign result_valid_o      = result_valid_q;
  assign line_shown_o        = shown_q;
  assign numbered_headword_o = numbered_q;
  assign entry_number_o      = number_q;
  assign last_line_o         = last_q;
  assign none_found_o        = none_q;

endmodule

// File: design/ahf_checker.sv
// ahf_checker: port-level checks for anchored_headword_filter, bound to it.
// Depends on ahf_pkg.
`timescale 1ns / 1ps

module ahf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      text_ready_o,
  input logic                      result_valid_o,
  input logic                      result_ready_i,
  input logic                      line_shown_o,
  input logic                      numbered_headword_o,
  input logic [ahf_pkg::CNT_W-1:0] entry_number_o,
  input logic                      last_line_o,
  input logic                      none_found_o
);

  // none_found only comes with the final line
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && none_found_o |-> last_line_o)
    else $error("none_found without last_line");

  // a numbered headword is always a shown line with a nonzero number
  a_numbered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && numbered_headword_o |-> line_shown_o && entry_number_o != '0)
    else $error("numbered headword not shown or number zero");

  // input stalls only behind a pending result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_ready_o |-> result_valid_o && !result_ready_i)
    else $error("input stalled without pending result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(entry_number_o))
    else $error("result dropped or changed while stalled");

endmodule

bind anchored_headword_filter ahf_checker u_ahf_checker (.*);

// File: tb/tb_anchored_headword_filter.sv
// Self-checking testbench for anchored_headword_filter: byte stream in, line decisions out.
// Holds its own line-decision predictor; depends on ahf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb_anchored_headword_filter;

  localparam int unsigned PAT_MAX    = 32;
  localparam int unsigned LINE_MAX   = 64;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned RAND_ITEMS = 500;
  localparam int unsigned TAIL_LINES = 20;
  localparam logic [7:0]  LETTER_A   = 8'h61;
  localparam logic [7:0]  LETTER_C   = 8'h63;

  typedef struct packed {
    logic        line_shown;
    logic        numbered_headword;
    logic [15:0] entry_number;
    logic        last_line;
    logic        none_found;
  } decision_t;

  // Mirror of the filter's line state and pattern registers.
  class line_decision_board;
    logic [7:0]  pat_bytes [ahf_pkg::PAT_BYTES];
    int unsigned pat_len;
    bit          anchor_s, anchor_e;
    logic [7:0]  window [PAT_MAX];
    int unsigned line_len;
    bit          headword, found_any, found_start, selected;
    int unsigned hits;
    decision_t   pending_decisions [$];
    int unsigned mismatches;
    int unsigned decisions_checked;

    function new();
      foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
      pat_len  = 1;
      anchor_s = 1'b0;
      anchor_e = 1'b0;
      selected = 1'b0;
      hits     = 0;
      mismatches = 0;
      decisions_checked = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (window[i]) window[i] = 8'h00;
      line_len    = 0;
      headword    = 1'b0;
      found_any   = 1'b0;
      found_start = 1'b0;
    endfunction

    function int unsigned used_len();
      return (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
    endfunction

    function bit is_space(logic [7:0] b);
      return (b == ahf_pkg::SPACE) || (b >= ahf_pkg::TAB && b <= ahf_pkg::CR);
    endfunction

    // Pattern ends at the newest byte of the line.
    function bit ends_here();
      int unsigned n;
      n = used_len();
      if (line_len < n) return 1'b0;
      for (int unsigned k = 0; k < n; k++)
        if (window[k] != pat_bytes[n-1-k]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_register(logic [ahf_pkg::CFG_IDX_W-1:0] idx,
                               logic [ahf_pkg::CFG_W-1:0] d);
      case (idx)
        ahf_pkg::CFG_PAT0, ahf_pkg::CFG_PAT1, ahf_pkg::CFG_PAT2, ahf_pkg::CFG_PAT3: begin
          for (int j = 0; j < 8; j++) pat_bytes[int'(idx) * 8 + j] = d[8*j +: 8];
        end
        ahf_pkg::CFG_PLEN:     pat_len  = d[5:0];
        ahf_pkg::CFG_ANCHOR_S: anchor_s = d[0];
        ahf_pkg::CFG_ANCHOR_E: anchor_e = d[0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic d);
      int unsigned n;
      bit          hit, at_end, numbered;
      decision_t   dec;
      n = used_len();
      numbered = 1'b0;
      if (line_len == 0) headword = !is_space(b);
      if (b != ahf_pkg::NEWLINE) begin
        for (int k = PAT_MAX - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = b;
        if (line_len < LINE_MAX) line_len++;
        if (ends_here()) begin
          found_any = 1'b1;
          if (line_len == n) found_start = 1'b1;
        end
        if (!d) return;
      end
      // line end: decide for headwords, continuation lines keep the last decision
      if (headword) begin
        if (n == 0) begin
          found_any   = 1'b1;
          found_start = 1'b1;
        end
        at_end = ends_here();
        if (anchor_s && anchor_e) hit = at_end && (line_len == n);
        else if (anchor_s)        hit = found_start;
        else if (anchor_e)        hit = at_end;
        else                      hit = found_any;
        if (hit) begin
          numbered = 1'b1;
          if (hits < 16'hFFFF) hits++;
        end
        selected = hit;
      end
      dec.line_shown        = selected;
      dec.numbered_headword = numbered;
      dec.entry_number      = hits[15:0];
      dec.last_line         = d;
      dec.none_found        = d && (hits == 0);
      pending_decisions.push_back(dec);
      clear_line();
      if (d) begin
        selected = 1'b0;
        hits     = 0;
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task match_decision(decision_t got);
      decision_t want;
      decisions_checked++;
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("decision with none pending (entry %0d)", got.entry_number));
        return;
      end
      want = pending_decisions.pop_front();
      if (got.line_shown !== want.line_shown)
        report_mismatch($sformatf("line_shown %b, want %b", got.line_shown, want.line_shown));
      if (got.numbered_headword !== want.numbered_headword)
        report_mismatch($sformatf("numbered_headword %b, want %b",
                                  got.numbered_headword, want.numbered_headword));
      if (got.entry_number !== want.entry_number)
        report_mismatch($sformatf("entry_number %0d, want %0d",
                                  got.entry_number, want.entry_number));
      if (got.last_line !== want.last_line)
        report_mismatch($sformatf("last_line %b, want %b", got.last_line, want.last_line));
      if (got.none_found !== want.none_found)
        report_mismatch($sformatf("none_found %b, want %b", got.none_found, want.none_found));
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [ahf_pkg::CFG_IDX_W-1:0] cfg_index_i    = ahf_pkg::CFG_PAT0;
  logic [ahf_pkg::CFG_W-1:0]     cfg_data_i     = '0;
  logic                          text_valid_i   = 1'b0;
  logic                          text_ready_o;
  logic [7:0]                    text_byte_i    = 8'h00;
  logic                          text_done_i    = 1'b0;
  logic                          result_valid_o;
  logic                          result_ready_i = 1'b0;
  logic                          line_shown_o;
  logic                          numbered_headword_o;
  logic [ahf_pkg::CNT_W-1:0]     entry_number_o;
  logic                          last_line_o;
  logic                          none_found_o;

  anchored_headword_filter #(
    .PATTERN_MAX(PAT_MAX),
    .LINE_LIMIT (LINE_MAX)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .text_valid_i       (text_valid_i),
    .text_ready_o       (text_ready_o),
    .text_byte_i        (text_byte_i),
    .text_done_i        (text_done_i),
    .result_valid_o     (result_valid_o),
    .result_ready_i     (result_ready_i),
    .line_shown_o       (line_shown_o),
    .numbered_headword_o(numbered_headword_o),
    .entry_number_o     (entry_number_o),
    .last_line_o        (last_line_o),
    .none_found_o       (none_found_o)
  );

  line_decision_board board = new();

  bit          idle_on = 1'b1;
  bit          tx_idle;
  bit          rx_quiet = 1'b0;
  int          rx_gap = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned settings_applied = 0;

  logic [7:0]  cur_pat [ahf_pkg::PAT_BYTES];
  int unsigned cur_len;
  bit          cur_as, cur_ae;
  logic [7:0]  text_q [$];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d decisions outstanding",
               cycles, board.pending_decisions.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Take results and drive ready; values sampled here are the pre-edge ones.
  always @(posedge clk_i) begin
    decision_t got;
    if (rst_ni && result_valid_o && result_ready_i) begin
      got.line_shown        = line_shown_o;
      got.numbered_headword = numbered_headword_o;
      got.entry_number      = entry_number_o;
      got.last_line         = last_line_o;
      got.none_found        = none_found_o;
      board.match_decision(got);
    end
    if (rx_gap > 0) begin
      rx_gap--;
      result_ready_i <= 1'b0;
    end else if (idle_on && !rx_quiet && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(1, 19) - 1;
      result_ready_i <= 1'b0;
    end else begin
      result_ready_i <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) rx_quiet = !rx_quiet;
  end

  function automatic int unsigned eff_len();
    return (cur_len > PAT_MAX) ? PAT_MAX : cur_len;
  endfunction

  function automatic void put(logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_letters(int n);
    for (int i = 0; i < n; i++) put(8'(LETTER_A + $urandom_range(0, 2)));
  endfunction

  function automatic void put_pat(int unsigned n);
    for (int unsigned i = 0; i < n; i++) put(cur_pat[i]);
  endfunction

  function automatic void set_pattern_str(string s);
    foreach (cur_pat[i]) cur_pat[i] = (i < s.len()) ? s[i] : 8'h00;
  endfunction

  // One dictionary line; the last line may end on a plain byte instead of a newline.
  function automatic void add_line(bit last);
    int unsigned n;
    int          body;
    n = eff_len();
    body = $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        case ($urandom_range(0, 4))
          0: begin
            put_pat(n);
            put_letters(body);
          end
          1: begin
            put_letters(1 + body);
            put_pat(n);
          end
          2: begin
            put_letters(1 + body);
            put_pat(n);
            put_letters($urandom_range(1, 3));
          end
          3: begin
            put_pat(n);
            if (n == 0) put_letters(1);
          end
          default: put_letters(1 + body);
        endcase
      end
      6, 7: begin
        case ($urandom_range(0, 2))
          0:       put(ahf_pkg::SPACE);
          1:       put(ahf_pkg::TAB);
          default: put(8'(ahf_pkg::TAB + $urandom_range(2, 4)));
        endcase
        put_letters(body);
        if ($urandom_range(0, 1)) put_pat(n);
      end
      8: ;
      default: begin
        for (int i = 0; i < 1 + body; i++) put(8'($urandom));
      end
    endcase
    if (!last || $urandom_range(0, 1)) put(ahf_pkg::NEWLINE);
  endfunction

  task automatic send_byte(logic [7:0] b, logic d);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      text_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    text_valid_i <= 1'b1;
    text_byte_i  <= b;
    text_done_i  <= d;
    do @(posedge clk_i); while (!text_ready_o);
    board.take_byte(b, d);
    bytes_sent++;
  endtask

  // Send the queued text with done on its last byte; valid stays up afterwards.
  task automatic send_text();
    if (text_q.size() == 0) put(ahf_pkg::NEWLINE);
    tx_idle = idle_on && ($urandom_range(0, 3) != 0);
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  // Drop valid and hold until every pending decision is out.
  task automatic drain();
    text_valid_i <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ahf_pkg::CFG_IDX_W-1:0] idx, logic [ahf_pkg::CFG_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    board.set_register(idx, d);
  endtask

  task automatic configure();
    logic [ahf_pkg::CFG_W-1:0] word [4];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 8; j++) word[i][8*j +: 8] = cur_pat[8*i + j];
    drain();
    write_reg(ahf_pkg::CFG_PAT0, word[0]);
    write_reg(ahf_pkg::CFG_PAT1, word[1]);
    write_reg(ahf_pkg::CFG_PAT2, word[2]);
    write_reg(ahf_pkg::CFG_PAT3, word[3]);
    write_reg(ahf_pkg::CFG_PLEN, 64'(cur_len));
    write_reg(ahf_pkg::CFG_ANCHOR_S, 64'(cur_as));
    write_reg(ahf_pkg::CFG_ANCHOR_E, 64'(cur_ae));
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // First four settings hit the length extremes and every anchor combination.
  task automatic random_setting(int unsigned k);
    foreach (cur_pat[i])
      cur_pat[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(LETTER_A + $urandom_range(0, 2));
    if (k < 4) begin
      case (k)
        0:       cur_len = 0;
        1:       cur_len = 1;
        2:       cur_len = PAT_MAX;
        default: cur_len = 63;
      endcase
      cur_as = k[0];
      cur_ae = k[1];
    end else begin
      case ($urandom_range(0, 9))
        0:       cur_len = 0;
        1:       cur_len = PAT_MAX;
        2:       cur_len = $urandom_range(PAT_MAX + 1, 63);
        default: cur_len = $urandom_range(1, 4);
      endcase
      cur_as = $urandom_range(0, 1);
      cur_ae = $urandom_range(0, 1);
    end
    configure();
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned setting_no;
    int          lines;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // substring match, continuation, empty line, byte extremes, final byte not a newline
    set_pattern_str("ab");
    cur_len = 2;
    cur_as  = 1'b0;
    cur_ae  = 1'b0;
    configure();
    put_str("cab\n");
    put_str(" x\n");
    put(ahf_pkg::NEWLINE);
    put(8'hFF);
    put(8'h00);
    put(ahf_pkg::NEWLINE);
    put_str("ab");
    send_text();

    // empty pattern with both anchors needs an empty line, which is never a headword
    cur_len = 0;
    cur_as  = 1'b1;
    cur_ae  = 1'b1;
    configure();
    put_str("a\n");
    put(ahf_pkg::NEWLINE);
    send_text();

    // oversized length reads as the full window with zero-filled pattern bytes
    set_pattern_str("a");
    cur_len = 63;
    cur_as  = 1'b1;
    cur_ae  = 1'b0;
    configure();
    put_str("a");
    send_text();

    // zero byte inside the pattern, suffix anchor
    set_pattern_str("a");
    cur_pat[1] = 8'h00;
    cur_len = 2;
    cur_as  = 1'b0;
    cur_ae  = 1'b1;
    configure();
    put_str("xa");
    put(8'h00);
    put(ahf_pkg::NEWLINE);
    send_text();

    // random dictionary texts
    rand_items = 0;
    setting_no = 0;
    while (rand_items < RAND_ITEMS) begin
      if (texts_sent % 2 == 0) begin
        random_setting(setting_no);
        setting_no++;
      end else if ($urandom_range(0, 3) == 0) begin
        drain();
      end
      lines = $urandom_range(1, 10);
      for (int i = 0; i < lines; i++) add_line(i == lines - 1);
      if ($urandom_range(0, 4) == 0) begin
        // broken stream: raw bytes glued on before the end
        for (int i = 0; i < 4; i++) put(8'($urandom));
      end
      rand_items += text_q.size();
      send_text();
    end

    // long lines saturate the length count; suffix still seen, prefix only early
    set_pattern_str("ab");
    cur_len = 2;
    cur_as  = 1'b0;
    cur_ae  = 1'b1;
    configure();
    put_str("ab");
    repeat (LINE_MAX + 3) put(LETTER_C);
    put_str("ab\n");
    send_text();
    cur_as = 1'b1;
    cur_ae = 1'b0;
    configure();
    put_str("ab");
    repeat (LINE_MAX + 3) put(LETTER_C);
    put_str("ab");
    send_text();

    // last part, no idling: short matching headwords back to back
    idle_on = 1'b0;
    set_pattern_str("a");
    cur_len = 1;
    cur_as  = 1'b0;
    cur_ae  = 1'b0;
    configure();
    repeat (TAIL_LINES) put_str("a\n");
    put_str("a");
    send_text();
    put_str("b");
    send_text();

    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d text bytes in %0d texts under %0d register settings",
             bytes_sent, texts_sent, settings_applied);
    $display("checked %0d line decisions, long lines past the length limit included",
             board.decisions_checked);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
